// ----- design/setup_message_field_parser_defines.svh -----
// assertion macros for the setup message field parser
// used by the files that carry concurrent assertions; expects clock and reset in scope
`ifndef SETUP_MESSAGE_FIELD_PARSER_DEFINES_SVH
`define SETUP_MESSAGE_FIELD_PARSER_DEFINES_SVH

// same-cycle implication
`define SMFP_ASSERT_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication
`define SMFP_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ----- design/smfp_pkg.sv -----
// types, constants and pair placement function for the setup message field parser
// no dependencies
package smfp_pkg;

   localparam int PairCount    = 9;
   localparam int PosWidth     = 6;
   localparam int PairWidth    = 7;
   localparam int SlotWidth    = $clog2(PairCount);

   localparam logic [PosWidth-1:0]  PosMax       = 6'd63;
   localparam logic [PosWidth-1:0]  SetupMinLen  = 6'd28;
   localparam logic [PosWidth-1:0]  TimeMinLen   = 6'd5;
   localparam int                   SetupFirstPos = 2;
   localparam int                   PairStride    = 3;

   localparam logic KindSetup = 1'b0;
   localparam logic KindTime  = 1'b1;

   localparam logic [6:0] DefYear     = 7'd24;
   localparam logic [3:0] DefMonth    = 4'd1;
   localparam logic [4:0] DefDay      = 5'd1;
   localparam logic [5:0] DefPoll     = 6'd10;
   localparam logic [6:0] DefLow      = 7'd20;
   localparam logic [6:0] DefMid      = 7'd30;
   localparam logic [6:0] DefHigh     = 7'd40;
   localparam logic [6:0] LevelStep   = 7'd5;
   localparam logic [6:0] MaxMonth    = 7'd12;
   localparam logic [6:0] MaxDay      = 7'd31;
   localparam logic [6:0] MaxHour     = 7'd23;
   localparam logic [6:0] MaxMinute   = 7'd59;
   localparam logic [6:0] MaxPoll     = 7'd60;

   localparam logic [7:0] CharNul     = 8'h00;
   localparam logic [7:0] CharZero    = 8'h30;
   localparam logic [7:0] CharNine    = 8'h39;

   typedef struct packed {
      logic       message_kind;
      logic [7:0] char_in;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [6:0] year_out;
      logic [3:0] month_out;
      logic [4:0] day_out;
      logic [4:0] hour_out;
      logic [5:0] minute_out;
      logic [5:0] poll_rate_out;
      logic [6:0] low_level_out;
      logic [6:0] mid_level_out;
      logic [6:0] high_level_out;
      logic       used_defaults;
   } rsp_type;

   typedef logic [PairCount-1:0][PairWidth-1:0] pair_array_type;

   typedef enum logic [1:0] {
      ROLE_NONE   = 2'd0,
      ROLE_FIRST  = 2'd1,
      ROLE_SECOND = 2'd2
   } role_type;

   typedef struct packed {
      role_type             role;
      logic [SlotWidth-1:0] slot;
   } locate_type;

   // where a character position falls within the digit pairs
   function automatic locate_type pair_locate(input logic kind, input logic [PosWidth-1:0] pos);
      locate_type loc;
      loc.role = ROLE_NONE;
      loc.slot = '0;
      if (kind == KindSetup) begin
         for (int s = 0; s < PairCount; s++) begin
            if (pos == PosWidth'(SetupFirstPos + PairStride * s)) begin
               loc.role = ROLE_FIRST;
               loc.slot = SlotWidth'(s);
            end
            if (pos == PosWidth'(SetupFirstPos + PairStride * s + 1)) begin
               loc.role = ROLE_SECOND;
               loc.slot = SlotWidth'(s);
            end
         end
      end else begin
         if (pos == PosWidth'(0)) begin
            loc.role = ROLE_FIRST;
         end else if (pos == PosWidth'(1)) begin
            loc.role = ROLE_SECOND;
         end else if (pos == PosWidth'(3)) begin
            loc.role = ROLE_FIRST;
            loc.slot = SlotWidth'(1);
         end else if (pos == PosWidth'(4)) begin
            loc.role = ROLE_SECOND;
            loc.slot = SlotWidth'(1);
         end
      end
      return loc;
   endfunction

endpackage

// ----- design/smfp_track.sv -----
// per-message state: length counter, terminator flag, pending first digit and decoded pairs
// depends on smfp_pkg
module smfp_track (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  smfp_pkg::req_type      item,
   output logic [5:0]             pos_upd,
   output smfp_pkg::pair_array_type pairs_upd
);
   import smfp_pkg::*;

   logic [PosWidth-1:0] pos_ff;
   logic                seen_ff;
   logic [3:0]          fd_ff;
   logic                fdok_ff;
   pair_array_type      pairs_ff;

   logic                seen_upd;
   logic [3:0]          fd_upd;
   logic                fdok_upd;
   logic                digit;
   logic [3:0]          digit_val;
   locate_type          loc;
   logic [PairWidth-1:0] pair_val;

   always_comb begin
      digit     = (item.char_in >= CharZero) && (item.char_in <= CharNine);
      digit_val = item.char_in[3:0];
      loc       = pair_locate(item.message_kind, pos_ff);
      pair_val  = {fd_ff, 3'b000} + {2'b00, fd_ff, 1'b0} + {3'b000, digit_val};
      pos_upd   = pos_ff;
      seen_upd  = seen_ff;
      fd_upd    = fd_ff;
      fdok_upd  = fdok_ff;
      pairs_upd = pairs_ff;
      if (!seen_ff) begin
         if (item.char_in == CharNul) begin
            seen_upd = 1'b1;
         end else begin
            unique case (loc.role)
               ROLE_FIRST: begin
                  fd_upd   = digit ? digit_val : 4'd0;
                  fdok_upd = digit;
               end
               ROLE_SECOND: begin
                  pairs_upd[loc.slot] = (fdok_ff && digit) ? pair_val : '0;
               end
               default: begin
               end
            endcase
            if (pos_ff != PosMax) begin
               pos_upd = pos_ff + 6'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         seen_ff  <= 1'b0;
         fd_ff    <= '0;
         fdok_ff  <= 1'b0;
         pairs_ff <= '0;
      end else if (step) begin
         if (item.last_char) begin
            pos_ff   <= '0;
            seen_ff  <= 1'b0;
            fd_ff    <= '0;
            fdok_ff  <= 1'b0;
            pairs_ff <= '0;
         end else begin
            pos_ff   <= pos_upd;
            seen_ff  <= seen_upd;
            fd_ff    <= fd_upd;
            fdok_ff  <= fdok_upd;
            pairs_ff <= pairs_upd;
         end
      end
   end

endmodule

// ----- design/smfp_decode.sv -----
// range checks, threshold ordering and default selection for one finished message
// depends on smfp_pkg
module smfp_decode (
   input  logic                     kind,
   input  logic [5:0]               pos,
   input  smfp_pkg::pair_array_type pairs,
   output smfp_pkg::rsp_type        result
);
   import smfp_pkg::*;

   logic [6:0] month;
   logic [6:0] day;
   logic [6:0] hour;
   logic [6:0] minute;
   logic [6:0] poll;
   logic [6:0] low;
   logic [6:0] mid;
   logic [6:0] high;
   logic [6:0] mid_fix;
   logic [6:0] high_fix;

   always_comb begin
      month   = (pairs[1] == '0 || pairs[1] > MaxMonth) ? 7'd1 : pairs[1];
      day     = (pairs[2] == '0 || pairs[2] > MaxDay) ? 7'd1 : pairs[2];
      hour    = (kind == KindTime) ? pairs[0] : pairs[3];
      minute  = (kind == KindTime) ? pairs[1] : pairs[4];
      hour    = (hour > MaxHour) ? 7'd0 : hour;
      minute  = (minute > MaxMinute) ? 7'd0 : minute;
      poll    = (pairs[5] == '0 || pairs[5] > MaxPoll) ? 7'd10 : pairs[5];
      low     = pairs[6];
      mid     = pairs[7];
      high    = pairs[8];
      mid_fix  = (low >= mid) ? low + LevelStep : mid;
      high_fix = (mid_fix >= high) ? mid_fix + LevelStep : high;

      result = '0;
      if (kind == KindSetup) begin
         if (pos < SetupMinLen) begin
            result.year_out       = DefYear;
            result.month_out      = DefMonth;
            result.day_out        = DefDay;
            result.poll_rate_out  = DefPoll;
            result.low_level_out  = DefLow;
            result.mid_level_out  = DefMid;
            result.high_level_out = DefHigh;
            result.used_defaults  = 1'b1;
         end else begin
            result.year_out       = pairs[0];
            result.month_out      = month[3:0];
            result.day_out        = day[4:0];
            result.hour_out       = hour[4:0];
            result.minute_out     = minute[5:0];
            result.poll_rate_out  = poll[5:0];
            result.low_level_out  = low;
            result.mid_level_out  = mid_fix;
            result.high_level_out = high_fix;
         end
      end else begin
         if (pos < TimeMinLen) begin
            result.used_defaults = 1'b1;
         end else begin
            result.hour_out   = hour[4:0];
            result.minute_out = minute[5:0];
         end
      end
   end

endmodule

// ----- design/setup_message_field_parser.sv -----
// top level of the setup message field parser: input register, message state, result register
// depends on smfp_pkg, smfp_track, smfp_decode and setup_message_field_parser_defines.svh
//
//   channel  | direction | ports                              | payload
//   req      | in        | req_valid, req_stall, req_data     | one character, kind, last marker
//   rsp      | out       | rsp_valid, rsp_stall, rsp_data     | decoded fields of one message
//
// one character per cycle unless a last character waits on a stalled result register
// the state update and field checks sit between the input register and the result register
// reset clears the message state and both valid flags, no clearing pass
// a stalled result holds only characters marked last; others keep flowing
`include "setup_message_field_parser_defines.svh"

module setup_message_field_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smfp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smfp_pkg::rsp_type rsp_data
);
   import smfp_pkg::*;

   logic           s1_valid_ff;
   logic           s1_valid_in;
   req_type        s1_item_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_type        rsp_data_ff;

   logic           out_free;
   logic           s1_go;
   logic           accept;
   logic           emit;
   logic [5:0]     pos_upd;
   pair_array_type pairs_upd;
   rsp_type        result;

   logic           setup_rsp;
   logic           levels_ordered;
   logic           date_ok;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_item_ff.last_char || out_free);
   assign emit      = s1_go && s1_item_ff.last_char;
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   smfp_track u_track (
      .clock     (clock),
      .reset     (reset),
      .step      (s1_go),
      .item      (s1_item_ff),
      .pos_upd   (pos_upd),
      .pairs_upd (pairs_upd)
   );

   smfp_decode u_decode (
      .kind   (s1_item_ff.message_kind),
      .pos    (pos_upd),
      .pairs  (pairs_upd),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_data;
      end
      if (emit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign setup_rsp      = rsp_valid && rsp_data.poll_rate_out != 6'd0;
   assign levels_ordered = rsp_data.mid_level_out > rsp_data.low_level_out &&
                           rsp_data.high_level_out > rsp_data.mid_level_out;
   assign date_ok        = rsp_data.month_out != 4'd0 && rsp_data.month_out <= 4'd12 &&
                           rsp_data.day_out != 5'd0;

   `SMFP_ASSERT_NOW(a_no_overwrite, emit, out_free, "result register overwritten while stalled")
   `SMFP_ASSERT_NEXT(a_stage_hold, req_stall, s1_valid_ff && $stable(s1_item_ff), "held character lost")
   `SMFP_ASSERT_NOW(a_level_order, setup_rsp, levels_ordered, "thresholds out of order")
   `SMFP_ASSERT_NOW(a_date_range, setup_rsp, date_ok, "date field out of range")

endmodule
